@@ src/ssk_pkg.sv @@
// ----------------------------------------------------------------------------
// ssk_pkg: shared types for the searchable stack
// Request codes, the controller state encoding and the shift command that
// the controller broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package ssk_pkg;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_SEARCH = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SEARCH = 2'b10
   } state_type;

   // shift_down moves every word one cell away from the top (push);
   // shift_up moves every word one cell toward the top (pop and rotate).
   typedef struct packed {
      logic shift_down;
      logic shift_up;
   } shift_type;

endpackage

@@ src/ssk_cell.sv @@
// ----------------------------------------------------------------------------
// ssk_cell: one storage cell of the stack
// Holds one word and, on command, takes the word of its neighbor above or
// below it.
// ----------------------------------------------------------------------------
module ssk_cell #(
   parameter int WORD_WIDTH = 32
) (
   input  logic                  clock,
   input  ssk_pkg::shift_type    shift,
   input  logic [WORD_WIDTH-1:0] from_above,
   input  logic [WORD_WIDTH-1:0] from_below,
   output logic [WORD_WIDTH-1:0] word
);
   import ssk_pkg::*;

   logic [WORD_WIDTH-1:0] word_ff;
   logic [WORD_WIDTH-1:0] word_in;

   always_comb begin
      priority if (shift.shift_down) begin
         word_in = from_above;
      end else if (shift.shift_up) begin
         word_in = from_below;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

@@ src/ssk_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssk_ctrl: controller of the searchable stack
// Keeps the fill count, issues shift commands to the cell row, runs the
// search sequence and registers every result.
// ----------------------------------------------------------------------------
module ssk_ctrl #(
   parameter int DEPTH      = 1024,
   parameter int WORD_WIDTH = 32,
   parameter int POS_W      = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_type,
   input  logic [WORD_WIDTH-1:0] req_value,
   input  logic [WORD_WIDTH-1:0] top_word,
   output logic                  busy,
   output ssk_pkg::shift_type    shift,
   output logic                  rsp_strobe,
   output logic                  rsp_ok,
   output logic [WORD_WIDTH-1:0] rsp_read_value,
   output logic [POS_W-1:0]      rsp_position,
   output logic                  rsp_found
);
   import ssk_pkg::*;

   localparam int STEP_W = $clog2(DEPTH);

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      count_ff, count_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [WORD_WIDTH-1:0] key_ff, key_in;
   logic                  hit_ff, hit_in;
   logic [POS_W-1:0]      dist_ff, dist_in;
   logic                  strobe_ff, strobe_in;
   logic                  ok_ff, ok_in;
   logic [WORD_WIDTH-1:0] read_ff, read_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  found_ff, found_in;
   req_code_type          code;

   assign code = req_code_type'(req_type);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      key_in    = key_ff;
      hit_in    = hit_ff;
      dist_in   = dist_ff;
      strobe_in = 1'b0;
      ok_in     = 1'b0;
      read_in   = '0;
      pos_in    = '0;
      found_in  = 1'b0;
      shift     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (code)
                  REQ_PUSH: begin
                     strobe_in = 1'b1;
                     if (count_ff != POS_W'(DEPTH)) begin
                        shift.shift_down = 1'b1;
                        count_in         = count_ff + POS_W'(1);
                        ok_in            = 1'b1;
                     end
                  end
                  REQ_POP: begin
                     strobe_in = 1'b1;
                     if (count_ff != '0) begin
                        shift.shift_up = 1'b1;
                        count_in       = count_ff - POS_W'(1);
                        ok_in          = 1'b1;
                        read_in        = top_word;
                     end
                  end
                  REQ_CLEAR: begin
                     strobe_in = 1'b1;
                     count_in  = '0;
                     ok_in     = 1'b1;
                  end
                  REQ_SEARCH: begin
                     state_in = ST_SEARCH;
                     step_in  = '0;
                     key_in   = req_value;
                     hit_in   = 1'b0;
                     dist_in  = '0;
                  end
                  default: begin
                     strobe_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            // The whole ring turns once; the top cell sees entry k at step k.
            shift.shift_up = 1'b1;
            step_in        = step_ff + STEP_W'(1);
            if (!hit_ff && (POS_W'(step_ff) < count_ff) && (top_word == key_ff)) begin
               hit_in  = 1'b1;
               dist_in = POS_W'(step_ff) + POS_W'(1);
            end
            if (step_ff == STEP_W'(DEPTH - 1)) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               ok_in     = 1'b1;
               pos_in    = dist_in;
               found_in  = hit_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      step_ff  <= step_in;
      key_ff   <= key_in;
      hit_ff   <= hit_in;
      dist_ff  <= dist_in;
      ok_ff    <= ok_in;
      read_ff  <= read_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_read_value = read_ff;
   assign rsp_position   = pos_ff;
   assign rsp_found      = found_ff;

endmodule

@@ src/searchable_stack.sv @@
// ----------------------------------------------------------------------------
// searchable_stack: bounded stack of words with a search by value
// An item is taken at a clock edge where start is high and busy is low;
// req_type picks push, pop, clear or search and req_value carries the word.
// Every item gives exactly one result, shown for one cycle with rsp_strobe.
// For push, pop and clear the result appears the cycle after the item is
// taken and busy stays low, so one such item fits every cycle.
// A search holds busy high while the row of DEPTH cells turns once as a
// ring past the top cell, where the word is compared; the result appears
// in the cycle in which busy falls.
// The ring length, not the fill count, sets the search time.
// Reset empties the stack; the cells themselves are not cleared.
// The receiver cannot stall: a result is valid only in its strobe cycle.
// ----------------------------------------------------------------------------
module searchable_stack #(
   parameter int DEPTH      = 1024,
   parameter int WORD_WIDTH = 32,
   localparam int POS_W     = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic [WORD_WIDTH-1:0] req_value,
   output logic                  rsp_strobe,
   output logic                  rsp_ok,
   output logic [WORD_WIDTH-1:0] rsp_read_value,
   output logic [POS_W-1:0]      rsp_position,
   output logic                  rsp_found
);
   import ssk_pkg::*;

   shift_type             shift;
   logic [WORD_WIDTH-1:0] cell_word [DEPTH];

   ssk_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .POS_W      (POS_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_type       (req_type),
      .req_value      (req_value),
      .top_word       (cell_word[0]),
      .busy           (busy),
      .shift          (shift),
      .rsp_strobe     (rsp_strobe),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_position   (rsp_position),
      .rsp_found      (rsp_found)
   );

   // Cell 0 is the top. The bottom cell takes the top word when shifting up,
   // which closes the ring used by search.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] above;
      logic [WORD_WIDTH-1:0] below;
      if (i == 0) begin : g_top
         assign above = req_value;
      end else begin : g_mid_above
         assign above = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_bottom
         assign below = cell_word[0];
      end else begin : g_mid_below
         assign below = cell_word[i+1];
      end
      ssk_cell #(
         .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .word       (cell_word[i])
      );
   end

endmodule

@@ tb/tb_searchable_stack.sv @@
// ----------------------------------------------------------------------------
// tb_searchable_stack: self-checking testbench for the searchable stack
// A short directed table covers the empty and duplicate cases, then
// random push, pop, clear and search items follow, with the stack filled to
// capacity once. Every result is compared against the typed answer where
// one is given, else against a behavioral copy of the stack held in the testbench.
// ----------------------------------------------------------------------------
module tb_searchable_stack;
   import ssk_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_DEPTH = 1024;
   localparam int WORD_W      = 32;
   localparam int POS_W       = 11;
   localparam int CLOCK_HALF  = 10;
   // Far above the slowest legal run: at most 589 searches, each turning the whole
   // ring, among 1632 items in all, each behind the longest input gap.
   localparam longint RUN_LIMIT_NS = 64'd80_000_000;

   typedef struct packed {
      logic              ok;
      logic [WORD_W-1:0] read_value;
      logic [POS_W-1:0]  position;
      logic              found;
   } stack_result_type;

   typedef struct packed {
      req_code_type      op;
      logic [WORD_W-1:0] value;
      logic              typed;
      stack_result_type  result;
   } directed_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_type;
   logic [WORD_W-1:0] req_value;
   logic              rsp_strobe;
   logic              rsp_ok;
   logic [WORD_W-1:0] rsp_read_value;
   logic [POS_W-1:0]  rsp_position;
   logic              rsp_found;

   // Behavioral copy of the stack.
   logic [WORD_W-1:0] stack_words [STACK_DEPTH];
   int                word_count;

   stack_result_type  expected_results [$];
   int                fail_count;
   int                stretch_left;
   bit                idle_on;

   // Expected results for the directed part: typed rows carry their answer,
   // the rest are worked out by apply_request.
   localparam int NUM_DIRECTED = 24;
   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{REQ_POP,    32'h0000_0000, 1'b1, '{1'b0, 32'h0, 11'd0, 1'b0}},
      '{REQ_SEARCH, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_CLEAR,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_PUSH,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_PUSH,   32'h0000_0000, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_PUSH,   32'hA5A5_A5A5, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_SEARCH, 32'hA5A5_A5A5, 1'b1, '{1'b1, 32'h0, 11'd1, 1'b1}},
      '{REQ_SEARCH, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 11'd3, 1'b1}},
      '{REQ_SEARCH, 32'h1234_5678, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_PUSH,   32'h0000_0000, 1'b0, '0},
      '{REQ_SEARCH, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 11'd1, 1'b1}},
      '{REQ_POP,    32'hDEAD_BEEF, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_SEARCH, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 11'd2, 1'b1}},
      '{REQ_POP,    32'h5A5A_5A5A, 1'b0, '0},
      '{REQ_POP,    32'hFFFF_FFFF, 1'b0, '0},
      '{REQ_POP,    32'h0000_0001, 1'b1, '{1'b1, 32'hFFFF_FFFF, 11'd0, 1'b0}},
      '{REQ_POP,    32'h8000_0000, 1'b1, '{1'b0, 32'h0, 11'd0, 1'b0}},
      '{REQ_PUSH,   32'h5555_AAAA, 1'b0, '0},
      '{REQ_PUSH,   32'h5555_AAAA, 1'b0, '0},
      '{REQ_CLEAR,  32'h0000_0000, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_SEARCH, 32'h5555_AAAA, 1'b1, '{1'b1, 32'h0, 11'd0, 1'b0}},
      '{REQ_POP,    32'h0000_0000, 1'b1, '{1'b0, 32'h0, 11'd0, 1'b0}},
      '{REQ_PUSH,   32'h8000_0001, 1'b0, '0},
      '{REQ_POP,    32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0001, 11'd0, 1'b0}}
   };

   searchable_stack #(
      .DEPTH      (STACK_DEPTH),
      .WORD_WIDTH (WORD_W)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_position   (rsp_position),
      .rsp_found      (rsp_found)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // Updates the stack copy for one accepted item and returns its result.
   function automatic stack_result_type apply_request(req_code_type op,
                                                      logic [WORD_W-1:0] word);
      stack_result_type res;
      int k;
      res = '0;
      case (op)
         REQ_PUSH: begin
            if (word_count < STACK_DEPTH) begin
               stack_words[word_count] = word;
               word_count++;
               res.ok = 1'b1;
            end
         end
         REQ_POP: begin
            if (word_count != 0) begin
               word_count--;
               res.ok = 1'b1;
               res.read_value = stack_words[word_count];
            end
         end
         REQ_CLEAR: begin
            word_count = 0;
            res.ok = 1'b1;
         end
         default: begin
            res.ok = 1'b1;
            for (k = 0; k < word_count && !res.found; k++) begin
               if (stack_words[word_count - 1 - k] == word) begin
                  res.position = POS_W'(k + 1);
                  res.found = 1'b1;
               end
            end
         end
      endcase
      return res;
   endfunction

   // Words that tend to repeat, so searches meet duplicates.
   function automatic logic [WORD_W-1:0] common_word();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0000_0001;
         3: return 32'h8000_0000;
         4: return 32'h0000_FFFF;
         default: return 32'hFFFF_0000;
      endcase
   endfunction

   // Drives one item after a random gap and queues its expected result once
   // the block takes it. A typed expectation replaces the predicted one.
   // Start stays high after the item is taken until the next call decides
   // whether to idle or to drive the next item.
   task automatic send_item(input req_code_type op, input logic [WORD_W-1:0] word,
                            input logic typed, input stack_result_type typed_result);
      int gap;
      stack_result_type predicted;
      if (stretch_left == 0) begin
         stretch_left = $urandom_range(10, 60);
         idle_on = ($urandom_range(0, 2) != 0);
      end
      stretch_left--;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_type  <= op;
      req_value <= word;
      do @(posedge clock); while (busy);
      predicted = apply_request(op, word);
      expected_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic run_random(input int count, input int push_w, input int pop_w,
                             input int search_w);
      int pick;
      req_code_type op;
      logic [WORD_W-1:0] word;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < push_w) op = REQ_PUSH;
         else if (pick < push_w + pop_w) op = REQ_POP;
         else if (pick < push_w + pop_w + search_w) op = REQ_SEARCH;
         else op = REQ_CLEAR;
         word = $urandom();
         if (op == REQ_PUSH && $urandom_range(0, 3) == 0) begin
            word = common_word();
         end else if (op == REQ_SEARCH && word_count != 0 &&
                      $urandom_range(0, 9) < 7) begin
            // Mostly search for a word that is stored somewhere.
            word = stack_words[$urandom_range(0, word_count - 1)];
         end
         send_item(op, word, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : check_results
      stack_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_ok);
               fail_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
               fail_count++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               fail_count++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int i;
      logic [WORD_W-1:0] bottom_word;
      logic [WORD_W-1:0] top_word;
      fail_count   = 0;
      word_count   = 0;
      stretch_left = 0;
      idle_on      = 1'b0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_type  <= REQ_PUSH;
      req_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < NUM_DIRECTED; i++) begin
         send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      end

      run_random(300, 45, 30, 22);

      // Fill to capacity with distinct words so the bottom entry is unique.
      send_item(REQ_CLEAR, $urandom(), 1'b0, '0);
      bottom_word = 32'h9E37_79B9;
      while (word_count < STACK_DEPTH) begin
         send_item(REQ_PUSH, WORD_W'(word_count + 1) * 32'h9E37_79B9, 1'b0, '0);
      end
      top_word = stack_words[STACK_DEPTH - 1];
      send_item(REQ_PUSH, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 11'd0, 1'b0});
      send_item(REQ_SEARCH, bottom_word, 1'b1, '{1'b1, 32'h0, 11'd1024, 1'b1});
      send_item(REQ_SEARCH, top_word, 1'b1, '{1'b1, 32'h0, 11'd1, 1'b1});

      // Hover near full so refused pushes and deep searches keep happening.
      run_random(280, 45, 40, 15);
      start <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (STACK_DEPTH + 2) @(posedge clock);
      if (fail_count == 0) begin
         $display("searchable_stack test passed");
      end else begin
         $display("searchable_stack test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("searchable_stack test failed");
      $finish;
   end

endmodule

@@ searchable_stack.f @@
src/ssk_pkg.sv
src/ssk_cell.sv
src/ssk_ctrl.sv
src/searchable_stack.sv
tb/tb_searchable_stack.sv
